@@ src/mma_pkg.sv @@
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants for the Mueller matrix datapath.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int OUT_W            = 36;
  localparam int ACC_W            = OUT_W + 1;
  localparam int NUM_AMP          = 4;
  localparam int NUM_PAIRS        = 6;
  localparam int NUM_ROWS         = 4;
  localparam int ROW_W            = 2;

  // amplitude slots: S1 = 0, S2 = 1, S3 = 2, S4 = 3
  // pair p forms S[PAIR_X[p]] * conj(S[PAIR_Y[p]])
  localparam int P23 = 0;
  localparam int P14 = 1;
  localparam int P24 = 2;
  localparam int P13 = 3;
  localparam int P12 = 4;
  localparam int P34 = 5;

  localparam int PAIR_X [NUM_PAIRS] = '{1, 0, 1, 0, 0, 2};
  localparam int PAIR_Y [NUM_PAIRS] = '{2, 3, 3, 2, 1, 3};

  typedef enum logic {
    CONV_BH = 1'b0,
    CONV_TM = 1'b1
  } conv_e;

  typedef logic [ROW_W-1:0] row_idx_t;
  localparam row_idx_t LAST_ROW = row_idx_t'(NUM_ROWS - 1);

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [OUT_W-1:0] elem_t;

  typedef struct packed {
    acc_t rr;
    acc_t ii;
    acc_t ir;
    acc_t ri;
  } xprod_t;

  typedef struct packed {
    acc_t   [NUM_AMP-1:0]   sq_re;
    acc_t   [NUM_AMP-1:0]   sq_im;
    xprod_t [NUM_PAIRS-1:0] xp;
  } prod_t;

  typedef struct packed {
    acc_t re;
    acc_t im;
  } cplx_t;

  typedef struct packed {
    acc_t  [NUM_AMP-1:0]   nrm;
    cplx_t [NUM_PAIRS-1:0] pr;
  } sums_t;

  typedef elem_t [NUM_ROWS-1:0]        row_t;
  typedef row_t  [NUM_ROWS-1:0]        mat_t;

endpackage

@@ src/mma_if.sv @@
// ----------------------------------------------------------------------------
// mma_if
// Valid/ready channels for amplitude items and Mueller rows.
// ----------------------------------------------------------------------------
interface mma_in_if #(
  parameter int SAMPLE_WIDTH = mma_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] s1_re;
  logic signed [SAMPLE_WIDTH-1:0] s1_im;
  logic signed [SAMPLE_WIDTH-1:0] s2_re;
  logic signed [SAMPLE_WIDTH-1:0] s2_im;
  logic signed [SAMPLE_WIDTH-1:0] s3_re;
  logic signed [SAMPLE_WIDTH-1:0] s3_im;
  logic signed [SAMPLE_WIDTH-1:0] s4_re;
  logic signed [SAMPLE_WIDTH-1:0] s4_im;

  modport source (
    output valid, s1_re, s1_im, s2_re, s2_im, s3_re, s3_im, s4_re, s4_im,
    input  ready
  );
  modport sink (
    input  valid, s1_re, s1_im, s2_re, s2_im, s3_re, s3_im, s4_re, s4_im,
    output ready
  );
endinterface

interface mma_out_if ();
  import mma_pkg::*;

  logic     valid;
  logic     ready;
  row_idx_t row_index;
  elem_t    col0;
  elem_t    col1;
  elem_t    col2;
  elem_t    col3;
  logic     last_row;

  modport source (
    output valid, row_index, col0, col1, col2, col3, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_index, col0, col1, col2, col3, last_row,
    output ready
  );
endinterface

@@ src/mma_mul.sv @@
// ----------------------------------------------------------------------------
// mma_mul
// Product stage: squares and cross products of the four amplitudes.
// ----------------------------------------------------------------------------
module mma_mul #(
  parameter int SAMPLE_WIDTH = mma_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 en_i,
  input  logic                                                 valid_i,
  input  logic [mma_pkg::NUM_AMP-1:0][SAMPLE_WIDTH-1:0]       re_i,
  input  logic [mma_pkg::NUM_AMP-1:0][SAMPLE_WIDTH-1:0]       im_i,
  output logic                                                 valid_o,
  output mma_pkg::prod_t                                       prod_o
);
  import mma_pkg::*;

  localparam int PW = 2 * SAMPLE_WIDTH;

  function automatic acc_t mul(input logic [SAMPLE_WIDTH-1:0] a,
                               input logic [SAMPLE_WIDTH-1:0] b);
    logic signed [PW-1:0] p;
    p = $signed(a) * $signed(b);
    return ACC_W'(p);
  endfunction

  prod_t prod_d, prod_q;
  logic  valid_q;

  always_comb begin
    for (int k = 0; k < NUM_AMP; k++) begin
      prod_d.sq_re[k] = mul(re_i[k], re_i[k]);
      prod_d.sq_im[k] = mul(im_i[k], im_i[k]);
    end
    for (int p = 0; p < NUM_PAIRS; p++) begin
      prod_d.xp[p].rr = mul(re_i[PAIR_X[p]], re_i[PAIR_Y[p]]);
      prod_d.xp[p].ii = mul(im_i[PAIR_X[p]], im_i[PAIR_Y[p]]);
      prod_d.xp[p].ir = mul(im_i[PAIR_X[p]], re_i[PAIR_Y[p]]);
      prod_d.xp[p].ri = mul(re_i[PAIR_X[p]], im_i[PAIR_Y[p]]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

@@ src/mma_sum.sv @@
// ----------------------------------------------------------------------------
// mma_sum
// Sum stage: squared magnitudes and products with the conjugate.
// ----------------------------------------------------------------------------
module mma_sum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  mma_pkg::prod_t  prod_i,
  output logic            valid_o,
  output mma_pkg::sums_t  sums_o
);
  import mma_pkg::*;

  sums_t sums_d, sums_q;
  logic  valid_q;

  always_comb begin
    for (int k = 0; k < NUM_AMP; k++) begin
      sums_d.nrm[k] = prod_i.sq_re[k] + prod_i.sq_im[k];
    end
    for (int p = 0; p < NUM_PAIRS; p++) begin
      sums_d.pr[p].re = prod_i.xp[p].rr + prod_i.xp[p].ii;
      sums_d.pr[p].im = prod_i.xp[p].ir - prod_i.xp[p].ri;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      sums_q <= sums_d;
    end
  end

  assign valid_o = valid_q;
  assign sums_o  = sums_q;

endmodule

@@ src/mma_form.sv @@
// ----------------------------------------------------------------------------
// mma_form
// Element stage: the sixteen Mueller elements for either convention.
// ----------------------------------------------------------------------------
module mma_form (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  mma_pkg::conv_e  conv_i,
  input  mma_pkg::sums_t  sums_i,
  output logic            valid_o,
  output mma_pkg::mat_t   mat_o
);
  import mma_pkg::*;

  acc_t  n1, n2, n3, n4;
  cplx_t p23, p14, p24, p13, p12, p34;
  acc_t  h0, h1, h4, h5;
  acc_t  e2, e6, e8, e9, e11;
  mat_t  mat_d, mat_q;
  logic  valid_q;

  always_comb begin
    n1  = sums_i.nrm[0];
    n2  = sums_i.nrm[1];
    n3  = sums_i.nrm[2];
    n4  = sums_i.nrm[3];
    p23 = sums_i.pr[P23];
    p14 = sums_i.pr[P14];
    p24 = sums_i.pr[P24];
    p13 = sums_i.pr[P13];
    p12 = sums_i.pr[P12];
    p34 = sums_i.pr[P34];

    h0 = n1 + n2 + n3 + n4;
    case (conv_i)
      CONV_TM: begin
        h1  = n2 - n3 + n4 - n1;
        h4  = n2 + n3 - n4 - n1;
        h5  = n2 - n3 - n4 + n1;
        e2  = -p14.re - p23.re;
        e6  = p14.re - p23.re;
        e8  = -p24.re - p13.re;
        e9  = p13.re - p24.re;
        e11 = p12.im + p34.im;
      end
      default: begin
        h1  = n2 - n1 + n4 - n3;
        h4  = n2 - n1 + n3 - n4;
        h5  = n1 + n2 - n3 - n4;
        e2  = p23.re + p14.re;
        e6  = p23.re - p14.re;
        e8  = p24.re + p13.re;
        e9  = p24.re - p13.re;
        e11 = -p12.im - p34.im;
      end
    endcase

    // halve by dropping the low bit of the wider sum
    mat_d[0][0] = h0[ACC_W-1:1];
    mat_d[0][1] = h1[ACC_W-1:1];
    mat_d[0][2] = e2[OUT_W-1:0];
    mat_d[0][3] = OUT_W'(p23.im - p14.im);

    mat_d[1][0] = h4[ACC_W-1:1];
    mat_d[1][1] = h5[ACC_W-1:1];
    mat_d[1][2] = e6[OUT_W-1:0];
    mat_d[1][3] = OUT_W'(p23.im + p14.im);

    mat_d[2][0] = e8[OUT_W-1:0];
    mat_d[2][1] = e9[OUT_W-1:0];
    mat_d[2][2] = OUT_W'(p12.re + p34.re);
    mat_d[2][3] = e11[OUT_W-1:0];

    mat_d[3][0] = OUT_W'(p13.im - p24.im);
    mat_d[3][1] = OUT_W'(-p24.im - p13.im);
    mat_d[3][2] = OUT_W'(p12.im - p34.im);
    mat_d[3][3] = OUT_W'(p12.re - p34.re);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      mat_q <= mat_d;
    end
  end

  assign valid_o = valid_q;
  assign mat_o   = mat_q;

endmodule

@@ src/mma_ser.sv @@
// ----------------------------------------------------------------------------
// mma_ser
// Row serializer: holds one matrix and sends it out a row per transfer.
// ----------------------------------------------------------------------------
module mma_ser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  mma_pkg::mat_t  mat_i,
  output logic           take_o,
  mma_out_if.source      out_o
);
  import mma_pkg::*;

  logic     busy_q, busy_d;
  row_idx_t row_q, row_d;
  mat_t     mat_q;
  logic     xfer;
  logic     last;

  assign xfer   = busy_q && out_o.ready;
  assign last   = (row_q == LAST_ROW);
  assign take_o = !busy_q || (xfer && last);

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    if (xfer) begin
      row_d = row_q + row_idx_t'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (take_o && valid_i) begin
      busy_d = 1'b1;
      row_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      mat_q <= mat_i;
    end
  end

  assign out_o.valid     = busy_q;
  assign out_o.row_index = row_q;
  assign out_o.col0      = mat_q[row_q][0];
  assign out_o.col1      = mat_q[row_q][1];
  assign out_o.col2      = mat_q[row_q][2];
  assign out_o.col3      = mat_q[row_q][3];
  assign out_o.last_row  = last;

endmodule

@@ src/mueller_matrix_from_amplitudes.sv @@
// Row 0 is offered once its matrix is taken into the serializer; rows 1..3 follow.
// One result channel, one row a cycle while ready; next matrix enters with the last row.
// The three datapath stages take an item every cycle until the row serializer backs up.
// Reset clears all stage valid bits and the serializer, and selects the
// Bohren-Huffman convention.
// ----------------------------------------------------------------------------
// mueller_matrix_from_amplitudes
// Mueller matrix from a 2x2 complex amplitude matrix, three-stage pipeline
// (products, sums, elements) followed by a row serializer.
// ----------------------------------------------------------------------------
module mueller_matrix_from_amplitudes #(
  parameter int SAMPLE_WIDTH = mma_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  mma_in_if.sink      in_i,
  mma_out_if.source   out_o
);
  import mma_pkg::*;

  conv_e  conv_q;
  logic   en1, en2, en3;
  logic   v1, v2, v3;
  logic   take;
  prod_t  prod;
  sums_t  sums;
  mat_t   mat;
  logic [NUM_AMP-1:0][SAMPLE_WIDTH-1:0] amp_re;
  logic [NUM_AMP-1:0][SAMPLE_WIDTH-1:0] amp_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= CONV_BH;
    end else if (cfg_we_i) begin
      conv_q <= conv_e'(cfg_wdata_i);
    end
  end

  // advance a stage when it is empty or its contents move on
  assign en3        = !v3 || take;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign in_i.ready = en1;

  assign amp_re[0] = in_i.s1_re;
  assign amp_im[0] = in_i.s1_im;
  assign amp_re[1] = in_i.s2_re;
  assign amp_im[1] = in_i.s2_im;
  assign amp_re[2] = in_i.s3_re;
  assign amp_im[2] = in_i.s3_im;
  assign amp_re[3] = in_i.s4_re;
  assign amp_im[3] = in_i.s4_im;

  mma_mul #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (in_i.valid),
    .re_i    (amp_re),
    .im_i    (amp_im),
    .valid_o (v1),
    .prod_o  (prod)
  );

  mma_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .prod_i  (prod),
    .valid_o (v2),
    .sums_o  (sums)
  );

  mma_form u_form (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2),
    .conv_i  (conv_q),
    .sums_i  (sums),
    .valid_o (v3),
    .mat_o   (mat)
  );

  mma_ser u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .mat_i   (mat),
    .take_o  (take),
    .out_o   (out_o)
  );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for mueller_matrix_from_amplitudes. A stimulus table, then random
// amplitude matrices, go in under both sign conventions, with random gaps on
// the input and random stalls on the row output. Each transfer in is turned
// into four expected rows, typed in for a few plain cases and otherwise
// computed here in 64-bit arithmetic, and every row out is compared with them.
// ----------------------------------------------------------------------------
module testbench;
  import mma_pkg::*;

  localparam int LIMIT  = 200000;
  localparam int N_PLAN = 22;
  localparam int N_RAND = 25;

  typedef logic signed [SAMPLE_WIDTH_DEF-1:0] sample_t;

  typedef struct {
    longint re;
    longint im;
  } phasor_t;

  typedef struct {
    conv_e   conv;
    sample_t s [8];
    bit      typed;
    elem_t   want [16];
  } vector_t;

  typedef struct {
    row_idx_t idx;
    elem_t    col [4];
    logic     last;
  } mrow_t;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    cfg_we_i;
  logic    cfg_wdata_i;
  conv_e   conv_now = CONV_BH;
  bit      failed = 1'b0;
  bit      tx_steady = 1'b0;
  bit      rx_steady = 1'b0;
  int      rx_hold = 0;
  int      cycle_count = 0;
  bit      cur_typed;
  elem_t   cur_want [16];
  mrow_t   rows_due [$];

  mma_in_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)) in_ch ();
  mma_out_if out_ch ();

  mueller_matrix_from_amplitudes #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #10 clk_i = ~clk_i;

  vector_t plan [N_PLAN] = '{
    '{CONV_BH, '{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{default: '0}},
    '{CONV_BH, '{1, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
      '{0, -1, 0, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{CONV_BH, '{-32768, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
      '{536870912, -536870912, 0, 0, -536870912, 536870912, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0}},
    '{CONV_BH, '{default: -32768}, 1'b0, '{default: '0}},
    '{CONV_BH, '{default: 32767}, 1'b0, '{default: '0}},
    '{CONV_BH, '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767},
      1'b0, '{default: '0}},
    '{CONV_BH, '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768},
      1'b0, '{default: '0}},
    '{CONV_BH, '{0, 0, -32768, 32767, 0, 0, 0, 0}, 1'b0, '{default: '0}},
    '{CONV_BH, '{0, 0, 0, 0, 32767, -32768, 0, 0}, 1'b0, '{default: '0}},
    '{CONV_BH, '{0, 0, 0, 0, 0, 0, 0, -32768}, 1'b0, '{default: '0}},
    '{CONV_BH, '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555}, 1'b0, '{default: '0}},
    '{CONV_BH, '{16384, 0, 16384, 0, 0, 0, 0, 0}, 1'b0, '{default: '0}},
    '{CONV_TM, '{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{default: '0}},
    '{CONV_TM, '{1, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
      '{0, -1, 0, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{CONV_TM, '{-32768, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
      '{536870912, -536870912, 0, 0, -536870912, 536870912, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0}},
    '{CONV_TM, '{default: -32768}, 1'b0, '{default: '0}},
    '{CONV_TM, '{default: 32767}, 1'b0, '{default: '0}},
    '{CONV_TM, '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767},
      1'b0, '{default: '0}},
    '{CONV_TM, '{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
                 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA}, 1'b0, '{default: '0}},
    '{CONV_TM, '{0, 0, 0, 0, -32768, 32767, 0, 0}, 1'b0, '{default: '0}},
    '{CONV_TM, '{0, 0, 0, 0, 0, 0, 32767, -32768}, 1'b0, '{default: '0}},
    '{CONV_TM, '{16384, 0, 16384, 0, 0, 0, 0, 0}, 1'b0, '{default: '0}}
  };

  // x * conj(y)
  function automatic phasor_t times_conj(phasor_t x, phasor_t y);
    phasor_t r;
    r.re = x.re * y.re + x.im * y.im;
    r.im = x.im * y.re - x.re * y.im;
    return r;
  endfunction

  function automatic void mueller_of(input sample_t s [8], input conv_e conv,
                                     output elem_t m [16]);
    phasor_t a [4];
    longint  n [4];
    longint  w [16];
    phasor_t p12, p13, p14, p23, p24, p34, p21;
    for (int k = 0; k < 4; k++) begin
      a[k].re = longint'(s[2*k]);
      a[k].im = longint'(s[2*k+1]);
      n[k] = a[k].re * a[k].re + a[k].im * a[k].im;
    end
    p12 = times_conj(a[0], a[1]);
    p13 = times_conj(a[0], a[2]);
    p14 = times_conj(a[0], a[3]);
    p23 = times_conj(a[1], a[2]);
    p24 = times_conj(a[1], a[3]);
    p34 = times_conj(a[2], a[3]);
    p21 = times_conj(a[1], a[0]);
    if (conv == CONV_TM) begin
      w[0]  = (n[1] + n[2] + n[3] + n[0]) >>> 1;
      w[1]  = (n[1] - n[2] + n[3] - n[0]) >>> 1;
      w[2]  = -p14.re - p23.re;
      w[3]  = p23.im - p14.im;
      w[4]  = (n[1] + n[2] - n[3] - n[0]) >>> 1;
      w[5]  = (n[1] - n[2] - n[3] + n[0]) >>> 1;
      w[6]  = p14.re - p23.re;
      w[7]  = p23.im + p14.im;
      w[8]  = -p24.re - p13.re;
      w[9]  = -p24.re + p13.re;
      w[10] = p21.re + p34.re;
      w[11] = -p21.im + p34.im;
      w[12] = -p24.im + p13.im;
      w[13] = -p24.im - p13.im;
      w[14] = p12.im - p34.im;
      w[15] = p12.re - p34.re;
    end else begin
      w[0]  = (n[0] + n[1] + n[2] + n[3]) >>> 1;
      w[1]  = (n[1] - n[0] + n[3] - n[2]) >>> 1;
      w[2]  = p23.re + p14.re;
      w[3]  = p23.im - p14.im;
      w[4]  = (n[1] - n[0] + n[2] - n[3]) >>> 1;
      w[5]  = (n[0] + n[1] - n[2] - n[3]) >>> 1;
      w[6]  = p23.re - p14.re;
      w[7]  = p23.im + p14.im;
      w[8]  = p24.re + p13.re;
      w[9]  = p24.re - p13.re;
      w[10] = p12.re + p34.re;
      w[11] = -p12.im - p34.im;
      w[12] = -p24.im + p13.im;
      w[13] = -p24.im - p13.im;
      w[14] = p12.im - p34.im;
      w[15] = p12.re - p34.re;
    end
    for (int i = 0; i < 16; i++) m[i] = elem_t'(w[i]);
  endfunction

  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3, 4: return sample_t'($urandom);
      5: begin
        case ($urandom_range(0, 4))
          0: return -32768;
          1: return 32767;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      6, 7: return sample_t'($urandom_range(0, 511) - 256);
      default: return sample_t'($urandom_range(0, 32767) - 16384);
    endcase
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // enter and leave at a falling edge
  task automatic send_amps(sample_t s [8], bit typed, elem_t want [16]);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_typed = typed;
    cur_want  = want;
    in_ch.valid <= 1'b1;
    in_ch.s1_re <= s[0];
    in_ch.s1_im <= s[1];
    in_ch.s2_re <= s[2];
    in_ch.s2_im <= s[3];
    in_ch.s3_re <= s[4];
    in_ch.s3_im <= s[5];
    in_ch.s4_re <= s[6];
    in_ch.s4_im <= s[7];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drain, then write the convention
  task automatic set_convention(conv_e c);
    in_ch.valid <= 1'b0;
    while (rows_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    conv_now = c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // row sink with random stalls
  always @(negedge clk_i) begin
    if ($urandom_range(0, 39) == 0) rx_steady <= !rx_steady;
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 99) < 25)
        rx_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
  end

  always @(posedge clk_i) begin
    sample_t got_in [8];
    elem_t   m [16];
    mrow_t   r;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        got_in = '{in_ch.s1_re, in_ch.s1_im, in_ch.s2_re, in_ch.s2_im,
                   in_ch.s3_re, in_ch.s3_im, in_ch.s4_re, in_ch.s4_im};
        if (cur_typed) m = cur_want;
        else mueller_of(got_in, conv_now, m);
        for (int k = 0; k < NUM_ROWS; k++) begin
          r.idx = row_idx_t'(k);
          for (int c = 0; c < 4; c++) r.col[c] = m[4*k+c];
          r.last = (k == NUM_ROWS - 1);
          rows_due = {rows_due, r};
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (rows_due.size() == 0) begin
          $error("row transfer with no row expected: row_index %0d", out_ch.row_index);
          failed = 1'b1;
        end else begin
          r = rows_due.pop_front();
          check_field("row_index", r.idx, out_ch.row_index);
          check_field("col0", r.col[0], out_ch.col0);
          check_field("col1", r.col[1], out_ch.col1);
          check_field("col2", r.col[2], out_ch.col2);
          check_field("col3", r.col[3], out_ch.col3);
          check_field("last_row", r.last, out_ch.last_row);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("mueller_matrix_from_amplitudes regression: fail");
      $finish;
    end
  end

  initial begin
    sample_t s [8];
    elem_t   none [16];
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    cur_typed    = 1'b0;
    none         = '{default: '0};
    cur_want     = none;
    in_ch.valid  = 1'b0;
    in_ch.s1_re  = '0;
    in_ch.s1_im  = '0;
    in_ch.s2_re  = '0;
    in_ch.s2_im  = '0;
    in_ch.s3_re  = '0;
    in_ch.s3_im  = '0;
    in_ch.s4_re  = '0;
    in_ch.s4_im  = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_convention(CONV_BH);

    foreach (plan[i]) begin
      if (plan[i].conv != conv_now) set_convention(plan[i].conv);
      send_amps(plan[i].s, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      if (conv_now == CONV_BH) set_convention(CONV_TM);
      else set_convention(CONV_BH);
      repeat (N_RAND) begin
        for (int k = 0; k < 8; k++) s[k] = pick_sample();
        send_amps(s, 1'b0, none);
      end
    end

    in_ch.valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (!failed) begin
      $display("mueller_matrix_from_amplitudes regression: pass");
    end else begin
      $display("mueller_matrix_from_amplitudes regression: fail");
    end
    $finish;
  end

endmodule

@@ mueller_matrix_from_amplitudes.f @@
src/mma_pkg.sv
src/mma_if.sv
src/mma_mul.sv
src/mma_sum.sv
src/mma_form.sv
src/mma_ser.sv
src/mueller_matrix_from_amplitudes.sv
test/testbench.sv
